### rtl/shared_exclusive_lock_table_unit_defines.svh
// Assertion macros shared by the lock table checker.
// No dependencies.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_UNIT_DEFINES_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_UNIT_DEFINES_SVH
// Assert that cond implies result in the following cycle.
`define SELT_ASSERT_NEXT(label, clk, rst_n, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);
// Assert that an expression holds at every clock.
`define SELT_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

### rtl/selt_pkg.sv
// Shared types and codes for the lock table unit.
// No dependencies.
package selt_pkg;
    localparam int TX_COUNT  = 16;
    localparam int RES_COUNT = 64;

    localparam logic [1:0] OP_SHARED    = 2'd0;
    localparam logic [1:0] OP_EXCL      = 2'd1;
    localparam logic [1:0] ST_GRANTED   = 2'd0;
    localparam logic [1:0] ST_WAIT      = 2'd1;
    localparam logic [1:0] ST_DEADLOCK  = 2'd2;
    localparam logic [1:0] ST_RELEASED  = 2'd3;

    typedef struct packed {
        logic clear_start;
        logic load;
        logic lock_eval;
        logic rel_step;
        logic rel_fin;
        logic reach_init;
        logic reach_step;
        logic dead_fin;
    } selt_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic bad;
        logic is_release;
        logic grant;
        logic rel_done;
        logic reach_done;
    } selt_sts_t;
endpackage

### rtl/shared_exclusive_lock_table_unit.sv
// Channel   | valid     | stall     | fields
// in        | in_valid  | in_stall  | opcode, tx_id, resource_id
// out       | out_valid | out_stall | status, blockers
// After reset a clearing pass zeroes every lock table slot before the first item.
// Lock request: answered after load and evaluation when granted or refused outright,
// else after up to TX_COUNT reachability rounds over the wait-for matrix.
// Release: one lock table slot per cycle; no sweep when the transaction id is invalid.
// A new item waits while an unclaimed result is stalled.
module shared_exclusive_lock_table_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [4:0]  tx_id,
    input  logic [5:0]  resource_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] blockers
);
    import selt_pkg::*;

    selt_cmd_t cmd;
    selt_sts_t sts;

    selt_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
    );

    selt_dp u_dp
    (
        .clk(clk), .rst_n(rst_n), .opcode(opcode), .tx_id(tx_id),
        .resource_id(resource_id), .out_stall(out_stall), .out_valid(out_valid),
        .status(status), .blockers(blockers), .cmd(cmd), .sts(sts)
    );
endmodule

### rtl/selt_ctrl.sv
// Controller state machine for the lock table unit.
// Depends on selt_pkg.
module selt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    output selt_pkg::selt_cmd_t cmd,
    input  selt_pkg::selt_sts_t sts
);
    import selt_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EVAL, S_REL, S_REACH} state_t;
    state_t state_reg, state_next;
    logic   busy;

    assign busy     = out_valid && out_stall;
    assign in_stall = (state_reg != S_IDLE) || busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && !busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.is_release)
                begin
                    cmd.rel_step = 1'b1;
                    state_next   = S_REL;
                end
                else
                begin
                    cmd.lock_eval = 1'b1;
                    if (sts.bad || sts.grant)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.reach_init = 1'b1;
                        state_next     = S_REACH;
                    end
                end
            end
            S_REL:
            begin
                cmd.rel_step = 1'b1;
                if (sts.rel_done)
                begin
                    cmd.rel_fin = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_REACH:
            begin
                cmd.reach_step = 1'b1;
                if (sts.reach_done)
                begin
                    cmd.dead_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end
endmodule

### rtl/selt_dp.sv
// Datapath: lock memories, wait-for matrix, release sweep, reachability.
// Depends on selt_pkg.
module selt_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          opcode,
    input  logic [4:0]          tx_id,
    input  logic [5:0]          resource_id,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [1:0]          status,
    output logic [15:0]         blockers,
    input  selt_pkg::selt_cmd_t cmd,
    output selt_pkg::selt_sts_t sts
);
    import selt_pkg::*;

    localparam int RW = (RES_COUNT > 1) ? $clog2(RES_COUNT) : 1;
    localparam int TW = $clog2(TX_COUNT);
    localparam int CW = $clog2(RES_COUNT + 1);
    localparam int NW = $clog2(TX_COUNT + 1);

    logic [TX_COUNT-1:0] sh_mem [RES_COUNT];
    logic [4:0]          ex_mem [RES_COUNT];
    logic [TX_COUNT-1:0] wf_reg [TX_COUNT];

    logic [1:0]          op_reg;
    logic [4:0]          tx_reg;
    logic [5:0]          res_reg;
    logic [CW-1:0]       cnt_reg;
    logic [TX_COUNT-1:0] sh_rd_reg;
    logic [4:0]          ex_rd_reg;
    logic [RW-1:0]       wr_addr_reg;
    logic                wr_pend_reg;
    logic [TX_COUNT-1:0] reach_reg, reach_next;
    logic [NW-1:0]       round_reg;
    logic [TX_COUNT-1:0] blk_reg;
    logic                clearing_reg;
    logic                valid_reg;
    logic [1:0]          status_reg;
    logic [15:0]         blockers_reg;

    logic                tx_ok, res_ok, other_ex, grant;
    logic [TX_COUNT-1:0] bit_tx, blk;
    logic [TW-1:0]       idx;
    logic [RW-1:0]       addr;

    assign tx_ok    = (tx_reg >= 5'd1) && ({27'd0, tx_reg} <= 32'(TX_COUNT));
    assign res_ok   = {26'd0, res_reg} < 32'(RES_COUNT);
    assign idx      = TW'(tx_reg - 5'd1);
    assign bit_tx   = tx_ok ? (TX_COUNT'(1) << idx) : '0;
    assign other_ex = (ex_rd_reg != 5'd0) && (ex_rd_reg != tx_reg);
    assign grant    = (op_reg == OP_SHARED) ? !other_ex
                    : (!other_ex && (sh_rd_reg == '0 || sh_rd_reg == bit_tx));
    assign addr     = cmd.load ? RW'(resource_id) : cnt_reg[RW-1:0];

    always_comb
    begin
        blk = '0;
        if (other_ex)
            blk = TX_COUNT'(1) << TW'(ex_rd_reg - 5'd1);
        if (op_reg == OP_EXCL)
            blk = blk | (sh_rd_reg & ~bit_tx);
        reach_next = reach_reg;
        for (int i = 0; i < TX_COUNT; i++)
        begin
            if (reach_reg[i])
                reach_next = reach_next | wf_reg[i];
        end
    end

    assign sts.clear_done = clearing_reg && (cnt_reg == CW'(RES_COUNT - 1));
    assign sts.is_release = op_reg[1];
    assign sts.bad        = !tx_ok || !res_ok;
    assign sts.grant      = grant;
    assign sts.rel_done   = !tx_ok || (cnt_reg == CW'(RES_COUNT));
    assign sts.reach_done = (reach_next == reach_reg) || (round_reg == NW'(TX_COUNT - 1));

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            sh_mem[addr] <= '0;
            ex_mem[addr] <= '0;
        end
        else if (wr_pend_reg)
        begin
            sh_mem[wr_addr_reg] <= sh_rd_reg & ~bit_tx;
            if (ex_rd_reg == tx_reg)
                ex_mem[wr_addr_reg] <= '0;
        end
        else if (cmd.lock_eval && !sts.bad && grant)
        begin
            if (op_reg == OP_SHARED)
                sh_mem[res_reg[RW-1:0]] <= sh_rd_reg | bit_tx;
            else
            begin
                sh_mem[res_reg[RW-1:0]] <= sh_rd_reg & ~bit_tx;
                ex_mem[res_reg[RW-1:0]] <= tx_reg;
            end
        end
        if (cmd.load)
        begin
            op_reg    <= opcode;
            tx_reg    <= tx_id;
            res_reg   <= resource_id;
        end
        if (cmd.load || cmd.rel_step)
        begin
            sh_rd_reg <= sh_mem[addr];
            ex_rd_reg <= ex_mem[addr];
        end
        if (cmd.rel_step)
            wr_addr_reg <= addr;
        if (cmd.reach_init)
        begin
            blk_reg   <= blk;
            reach_reg <= blk;
            round_reg <= '0;
        end
        else if (cmd.reach_step)
        begin
            reach_reg <= reach_next;
            round_reg <= round_reg + NW'(1);
        end
        if (cmd.lock_eval)
        begin
            blockers_reg <= '0;
            status_reg   <= sts.bad ? ST_DEADLOCK : (grant ? ST_GRANTED : ST_WAIT);
        end
        if (cmd.dead_fin)
        begin
            if (reach_next[idx])
            begin
                status_reg   <= ST_DEADLOCK;
                blockers_reg <= '0;
            end
            else
            begin
                status_reg   <= ST_WAIT;
                blockers_reg <= 16'(blk_reg);
            end
        end
        if (cmd.rel_fin)
        begin
            status_reg   <= ST_RELEASED;
            blockers_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            cnt_reg      <= '0;
            valid_reg    <= 1'b0;
            wr_pend_reg  <= 1'b0;
            for (int i = 0; i < TX_COUNT; i++)
                wf_reg[i] <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (sts.clear_done)
                begin
                    clearing_reg <= 1'b0;
                    cnt_reg      <= '0;
                end
                else
                    cnt_reg <= cnt_reg + CW'(1);
            end
            else if (cmd.rel_step)
                cnt_reg <= sts.rel_done ? '0 : cnt_reg + CW'(1);
            wr_pend_reg <= cmd.rel_step && tx_ok && !sts.rel_done;
            if (cmd.rel_fin && tx_ok)
            begin
                for (int i = 0; i < TX_COUNT; i++)
                    wf_reg[i] <= (TW'(i) == idx) ? '0 : (wf_reg[i] & ~bit_tx);
            end
            if (cmd.lock_eval && !sts.bad)
                wf_reg[idx] <= grant ? '0 : blk;
            if (cmd.dead_fin && reach_next[idx])
                wf_reg[idx] <= '0;
            if (cmd.lock_eval && (sts.bad || grant))
                valid_reg <= 1'b1;
            else if (cmd.rel_fin || cmd.dead_fin)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign blockers  = blockers_reg;
endmodule

### rtl/selt_checker.sv
// Port checker for the lock table unit, bound to the top level.
// Depends on selt_pkg and shared_exclusive_lock_table_unit_defines.svh.
`include "shared_exclusive_lock_table_unit_defines.svh"
module selt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] blockers
);
    import selt_pkg::*;

    `SELT_ASSERT_ALWAYS(a_blk_wait, clk, rst_n, !out_valid || status == ST_WAIT || blockers == 16'd0, "blockers set without wait")
    `SELT_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall, "accepted back to back")
    `SELT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(blockers), "stalled result changed")
    `SELT_ASSERT_ALWAYS(a_no_take, clk, rst_n, !(out_valid && out_stall) || in_stall, "input taken while output stalled")
endmodule

bind shared_exclusive_lock_table_unit selt_checker u_selt_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .blockers(blockers)
);

### sim/shared_exclusive_lock_table_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the shared/exclusive lock table unit with deadlock detection.
// Depends on selt_pkg and shared_exclusive_lock_table_unit.
module shared_exclusive_lock_table_unit_tb;
    import selt_pkg::*;

    localparam int TXN_MAX   = 16;
    localparam int SLOT_MAX  = 64;
    localparam int WDOG_MAX  = 20000;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] txn;
        logic [5:0] slot;
    } lock_req_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [15:0] blk;
    } lock_resp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [4:0]  tx_id;
    logic [5:0]  resource_id;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] blockers;

    lock_req_t  pending_reqs[$];
    lock_resp_t expected_resps[$];
    logic [15:0] sh_set[SLOT_MAX];
    logic [4:0]  ex_owner[SLOT_MAX];
    logic [15:0] waits_row[TXN_MAX];
    int  mismatch_count;
    int  idle_cycles;
    int  in_gap;
    int  out_gap;
    bit  quiet_phase;
    bit  hold_sender;

    shared_exclusive_lock_table_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .tx_id(tx_id), .resource_id(resource_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .blockers(blockers)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic bit cycle_back(logic [15:0] start, int self_idx);
        logic [15:0] reach;
        logic [15:0] nxt;
        reach = start;
        for (int r = 0; r < TXN_MAX; r++)
        begin
            nxt = reach;
            for (int i = 0; i < TXN_MAX; i++)
                if (reach[i]) nxt |= waits_row[i];
            if (nxt == reach) break;
            reach = nxt;
        end
        return reach[self_idx];
    endfunction

    function automatic lock_resp_t apply_lock_request(lock_req_t q);
        lock_resp_t rsp;
        logic [15:0] bit_m;
        logic [15:0] blk;
        logic [15:0] sh;
        logic [4:0]  ex;
        bit ok_tx;
        bit other_ex;
        bit grant;
        int idx;
        rsp = '0;
        ok_tx = q.txn >= 1 && q.txn <= TXN_MAX;
        if (q.op >= OP_RELEASE)
        begin
            if (ok_tx)
            begin
                bit_m = 16'(1) << (q.txn - 1);
                for (int r = 0; r < SLOT_MAX; r++)
                begin
                    sh_set[r] &= ~bit_m;
                    if (ex_owner[r] == q.txn) ex_owner[r] = '0;
                end
                waits_row[q.txn - 1] = '0;
                for (int t = 0; t < TXN_MAX; t++) waits_row[t] &= ~bit_m;
            end
            rsp.st = ST_RELEASED;
        end
        else if (!ok_tx)
            rsp.st = ST_DEADLOCK;
        else
        begin
            idx = q.txn - 1;
            bit_m = 16'(1) << idx;
            ex = ex_owner[q.slot];
            sh = sh_set[q.slot];
            other_ex = ex != 0 && ex != q.txn;
            grant = (q.op == OP_SHARED) ? !other_ex
                                        : (!other_ex && (sh == 0 || sh == bit_m));
            if (grant)
            begin
                if (q.op == OP_SHARED)
                    sh_set[q.slot] = sh | bit_m;
                else
                begin
                    sh_set[q.slot] = sh & ~bit_m;
                    ex_owner[q.slot] = q.txn;
                end
                waits_row[idx] = '0;
                rsp.st = ST_GRANTED;
            end
            else
            begin
                blk = '0;
                if (other_ex) blk[ex - 1] = 1'b1;
                if (q.op == OP_EXCL) blk |= sh & ~bit_m;
                waits_row[idx] = blk;
                if (cycle_back(blk, idx))
                begin
                    waits_row[idx] = '0;
                    rsp.st = ST_DEADLOCK;
                end
                else
                begin
                    rsp.st = ST_WAIT;
                    rsp.blk = blk;
                end
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lock_req_t q;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= '0;
            tx_id <= '0;
            resource_id <= '0;
            in_gap = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                expected_resps.push_back(apply_lock_request({opcode, tx_id, resource_id}));
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (hold_sender || pending_reqs.size() == 0
                     || (in_valid && pending_reqs.size() == 0))
                in_valid <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                in_gap = $urandom_range(0, 5);
                in_valid <= 1'b0;
            end
            else
            begin
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                opcode <= q.op;
                tx_id <= q.txn;
                resource_id <= q.slot;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        lock_resp_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_resps.size() == 0)
                    report_mismatch("unexpected result", {14'd0, status}, 16'd0);
                else
                begin
                    want = expected_resps.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", {14'd0, status}, {14'd0, want.st});
                    if (blockers !== want.blk) report_mismatch("blockers", blockers, want.blk);
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(0, 5);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_req(logic [1:0] op, logic [4:0] txn, logic [5:0] slot);
        pending_reqs.push_back({op, txn, slot});
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int txn_hi;
        mismatch_count = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        hold_sender = 1'b0;
        for (int r = 0; r < SLOT_MAX; r++)
        begin
            sh_set[r] = '0;
            ex_owner[r] = '0;
        end
        for (int t = 0; t < TXN_MAX; t++) waits_row[t] = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        #0.5 rst_n = 1'b1;

        add_req(OP_SHARED, 5'd1, 6'd0);
        add_req(OP_SHARED, 5'd16, 6'd0);
        add_req(OP_EXCL, 5'd1, 6'd0);
        add_req(OP_EXCL, 5'd2, 6'd63);
        add_req(OP_EXCL, 5'd1, 6'd63);
        add_req(OP_EXCL, 5'd16, 6'd63);
        add_req(OP_EXCL, 5'd2, 6'd0);
        add_req(OP_SHARED, 5'd2, 6'd63);
        add_req(OP_EXCL, 5'd2, 6'd63);
        add_req(OP_SHARED, 5'd0, 6'd5);
        add_req(OP_EXCL, 5'd17, 6'd5);
        add_req(OP_EXCL, 5'd31, 6'd42);
        add_req(OP_RELEASE, 5'd0, 6'd0);
        add_req(OP_RELEASE, 5'd31, 6'd21);
        add_req(2'd3, 5'd16, 6'd0);
        add_req(OP_EXCL, 5'd3, 6'd10);
        add_req(OP_EXCL, 5'd4, 6'd11);
        add_req(OP_EXCL, 5'd3, 6'd11);
        add_req(OP_EXCL, 5'd4, 6'd10);
        add_req(OP_SHARED, 5'd4, 6'd10);
        add_req(2'd3, 5'd3, 6'd63);
        add_req(OP_RELEASE, 5'd4, 6'd0);
        add_req(OP_RELEASE, 5'd1, 6'd0);
        add_req(OP_RELEASE, 5'd2, 6'd0);

        hold_sender = 1'b1;
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        for (int n = 0; n < 1350; n++)
        begin
            if (n == 1200) quiet_phase = 1'b1;
            if (n == 600)
            begin
                wait_drained();
                hold_sender = 1'b1;
                repeat (10) @(posedge clk);
                hold_sender = 1'b0;
            end
            kind = $urandom_range(0, 99);
            txn_hi = (n % 300 < 150) ? 4 : 16;
            if (kind < 3)
                add_req(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                        6'($urandom_range(0, 63)));
            else if (kind < 12)
                add_req(2'($urandom_range(2, 3)), 5'($urandom_range(1, txn_hi)),
                        6'($urandom_range(0, 63)));
            else
                add_req(2'($urandom_range(0, 1)), 5'($urandom_range(1, txn_hi)),
                        6'((kind < 80) ? $urandom_range(0, 7) : $urandom_range(0, 63)));
            if (pending_reqs.size() > 32)
                while (pending_reqs.size() > 8) @(posedge clk);
        end
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/selt_pkg.sv
rtl/selt_ctrl.sv
rtl/selt_dp.sv
rtl/shared_exclusive_lock_table_unit.sv
rtl/selt_checker.sv
sim/shared_exclusive_lock_table_unit_tb.sv
